### rtl/mlm_pkg.sv
// Shared constants, types and codes for the mutex lock manager.
package mlm_pkg;

  // Bank size and per-mutex wait queue depth.
  localparam int MUTEX_COUNT = 4;
  localparam int QUEUE_DEPTH = 16;

  // Field widths fixed by the interface.
  localparam int PID_W = 8;
  localparam int ID_W  = 3;
  localparam int ST_W  = 3;

  // Derived widths for indexes and counters.
  localparam int MID_W   = (MUTEX_COUNT > 1) ? $clog2(MUTEX_COUNT) : 1;
  localparam int IDX_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W   = ((IDX_W > CNT_W) ? IDX_W : CNT_W) + 1;
  localparam int RING_D  = MUTEX_COUNT * QUEUE_DEPTH;
  localparam int RING_AW = (RING_D > 1) ? $clog2(RING_D) : 1;

  // Operation codes.
  localparam logic OP_WAIT   = 1'b0;
  localparam logic OP_SIGNAL = 1'b1;

  // Result status codes.
  localparam logic [ST_W-1:0] ST_ACQUIRED  = 3'd0;
  localparam logic [ST_W-1:0] ST_BLOCKED   = 3'd1;
  localparam logic [ST_W-1:0] ST_FREED     = 3'd2;
  localparam logic [ST_W-1:0] ST_HANDOFF   = 3'd3;
  localparam logic [ST_W-1:0] ST_NOT_OWNER = 3'd4;
  localparam logic [ST_W-1:0] ST_UNKNOWN   = 3'd5;
  localparam logic [ST_W-1:0] ST_FULL      = 3'd6;

  // One control entry per mutex, held in the control memory.
  typedef struct packed {
    logic             lock;
    logic [PID_W-1:0] owner;
    logic [IDX_W-1:0] head;
    logic [CNT_W-1:0] count;
  } ctrl_entry_t;

  localparam int CTRL_W = $bits(ctrl_entry_t);

  // Decision handed from the evaluation logic to the sequencer.
  typedef struct packed {
    logic [ST_W-1:0]  status;
    logic             ctrl_we;
    logic             ring_we;
    logic             ring_re;
    logic [IDX_W-1:0] ring_idx;
    ctrl_entry_t      entry;
  } decision_t;

endpackage

### rtl/mutex_lock_manager_fifo_core.sv
// Top level of the mutex lock manager: sequencer, control memory and wait ring.
//
//  Channel | Direction | Handshake            | Payload
//  in      | input     | in_valid / in_ready  | in_op, in_mutex_id, in_process_id
//  out     | output    | out_valid / out_ready| out_status, out_handoff_pid,
//          |           |                      | out_handoff_valid
//
// A transaction reads the control entry on acceptance, then evaluates and writes
// back. A handoff first reads the oldest waiter from the ring memory, then
// writes back. The registered reads of the two memories set these steps.
// Reset clears the sequencer, the output valid and the entry valid bits at
// once; no clearing pass is needed. A stalled result holds in the output
// register while the next transaction is accepted and read.
module mutex_lock_manager_fifo_core import mlm_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             in_op,
  input  logic [ID_W-1:0]  in_mutex_id,
  input  logic [PID_W-1:0] in_process_id,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [ST_W-1:0]  out_status,
  output logic [PID_W-1:0] out_handoff_pid,
  output logic             out_handoff_valid
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EVAL = 2'd1;
  localparam logic [1:0] S_HAND = 2'd2;

  logic [1:0]             state_r, state_nxt;
  logic                   op_r;
  logic [ID_W-1:0]        mid_r;
  logic [PID_W-1:0]       pid_r;
  logic [MUTEX_COUNT-1:0] vld_r, vld_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [ST_W-1:0]        out_status_r;
  logic [PID_W-1:0]       out_pid_r;
  logic                   out_hv_r;

  logic                   in_fire;
  logic                   out_free;
  logic                   known;
  logic [MID_W-1:0]       cur_mid;
  logic [CTRL_W-1:0]      ctrl_rdata;
  logic [CTRL_W-1:0]      ctrl_wdata;
  logic                   ctrl_we;
  ctrl_entry_t            cur_entry;
  ctrl_entry_t            wr_entry;
  decision_t              dec;
  logic                   ring_we;
  logic                   ring_re;
  logic [RING_AW-1:0]     ring_addr;
  logic [PID_W-1:0]       ring_rdata;
  logic                   load_out;
  logic [ST_W-1:0]        load_status;
  logic [PID_W-1:0]       load_pid;
  logic                   load_hv;

  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign cur_mid  = mid_r[MID_W-1:0];
  assign known    = ({1'b0, mid_r} < (ID_W + 1)'(MUTEX_COUNT));

  // An entry never written reads as the reset value.
  assign cur_entry = vld_r[cur_mid] ? ctrl_entry_t'(ctrl_rdata) : '0;

  mlm_decide u_decide (
    .op    (op_r),
    .known (known),
    .pid   (pid_r),
    .cur   (cur_entry),
    .dec   (dec)
  );

  // Ring address: the mutex's slice plus the slot inside it.
  assign ring_addr = RING_AW'(cur_mid) * RING_AW'(QUEUE_DEPTH) + RING_AW'(dec.ring_idx);

  // Sequencer: evaluate, optionally fetch the waiter, then write back.
  always_comb begin
    state_nxt   = state_r;
    ctrl_we     = 1'b0;
    ring_we     = 1'b0;
    ring_re     = 1'b0;
    load_out    = 1'b0;
    load_status = dec.status;
    load_pid    = '0;
    load_hv     = 1'b0;
    wr_entry    = dec.entry;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        if (dec.ring_re) begin
          ring_re   = 1'b1;
          state_nxt = S_HAND;
        end else if (out_free) begin
          ctrl_we   = dec.ctrl_we;
          ring_we   = dec.ring_we;
          load_out  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_HAND: begin
        wr_entry.owner = ring_rdata;
        if (out_free) begin
          ctrl_we   = 1'b1;
          load_out  = 1'b1;
          load_pid  = ring_rdata;
          load_hv   = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign ctrl_wdata = CTRL_W'(wr_entry);

  // Entry valid bits and output valid.
  always_comb begin
    vld_nxt = vld_r;
    if (ctrl_we) begin
      vld_nxt[cur_mid] = 1'b1;
    end
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      vld_r       <= vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Captured request and result payload.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r  <= in_op;
      mid_r <= in_mutex_id;
      pid_r <= in_process_id;
    end
    if (load_out) begin
      out_status_r <= load_status;
      out_pid_r    <= load_pid;
      out_hv_r     <= load_hv;
    end
  end

  mlm_ram #(
    .WIDTH (CTRL_W),
    .DEPTH (MUTEX_COUNT)
  ) u_ctrl_ram (
    .clk   (clk),
    .we    (ctrl_we),
    .waddr (cur_mid),
    .wdata (ctrl_wdata),
    .re    (in_fire),
    .raddr (in_mutex_id[MID_W-1:0]),
    .rdata (ctrl_rdata)
  );

  mlm_ram #(
    .WIDTH (PID_W),
    .DEPTH (RING_D)
  ) u_ring_ram (
    .clk   (clk),
    .we    (ring_we),
    .waddr (ring_addr),
    .wdata (pid_r),
    .re    (ring_re),
    .raddr (ring_addr),
    .rdata (ring_rdata)
  );

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_handoff_pid   = out_pid_r;
  assign out_handoff_valid = out_hv_r;

  // An accepted transaction is always evaluated in the next cycle.
  a_fire_eval: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == S_EVAL))
    else $error("accepted transaction not evaluated");

  // The ring is never written and read in the same cycle.
  a_ring_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(ring_we && ring_re))
    else $error("ring read and write collide");

  // Write back to the control memory only with a result being loaded.
  a_wb_result: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl_we |-> (load_out && (state_r != S_IDLE)))
    else $error("control write without result");

  // A handoff flag appears only with the handoff status.
  a_hv_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_hv_r) |-> (out_status_r == ST_HANDOFF))
    else $error("handoff flag with wrong status");

  // A pending result is not overwritten while stalled.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> (out_valid_r && $stable(out_status_r)))
    else $error("stalled result overwritten");

endmodule

### rtl/mlm_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
module mlm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read; read data holds between reads.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/mlm_decide.sv
// Evaluation of one request against the current control entry of its mutex.
module mlm_decide import mlm_pkg::*; (
  input  logic             op,
  input  logic             known,
  input  logic [PID_W-1:0] pid,
  input  ctrl_entry_t      cur,
  output decision_t        dec
);

  logic [SUM_W-1:0] tail_sum;
  logic [IDX_W-1:0] tail_idx;
  logic [IDX_W-1:0] head_nxt;
  logic             full;

  // Tail of the ring: head plus count, wrapped once; also the next head and the full flag.
  always_comb begin
    tail_sum = SUM_W'(cur.head) + SUM_W'(cur.count);
    if (tail_sum >= SUM_W'(QUEUE_DEPTH)) begin
      tail_idx = IDX_W'(tail_sum - SUM_W'(QUEUE_DEPTH));
    end else begin
      tail_idx = IDX_W'(tail_sum);
    end
    if (cur.head == IDX_W'(QUEUE_DEPTH - 1)) begin
      head_nxt = '0;
    end else begin
      head_nxt = cur.head + IDX_W'(1);
    end
    full = (cur.count >= CNT_W'(QUEUE_DEPTH));
  end

  // Request decision; order of the checks matters.
  always_comb begin
    dec          = '0;
    dec.entry    = cur;
    dec.ring_idx = cur.head;
    dec.status   = ST_UNKNOWN;
    priority if (!known) begin
      dec.status = ST_UNKNOWN;
    end else if (op == OP_WAIT) begin
      priority if (!cur.lock) begin
        dec.entry.lock  = 1'b1;
        dec.entry.owner = pid;
        dec.ctrl_we     = 1'b1;
        dec.status      = ST_ACQUIRED;
      end else if (full) begin
        dec.status = ST_FULL;
      end else begin
        dec.ring_we     = 1'b1;
        dec.ring_idx    = tail_idx;
        dec.entry.count = cur.count + CNT_W'(1);
        dec.ctrl_we     = 1'b1;
        dec.status      = ST_BLOCKED;
      end
    end else begin
      priority if (!cur.lock || (cur.owner != pid)) begin
        dec.status = ST_NOT_OWNER;
      end else if (cur.count != '0) begin
        // The new owner comes from the ring read that follows.
        dec.ring_re     = 1'b1;
        dec.ring_idx    = cur.head;
        dec.entry.head  = head_nxt;
        dec.entry.count = cur.count - CNT_W'(1);
        dec.ctrl_we     = 1'b1;
        dec.status      = ST_HANDOFF;
      end else begin
        dec.entry.lock  = 1'b0;
        dec.entry.owner = '0;
        dec.ctrl_we     = 1'b1;
        dec.status      = ST_FREED;
      end
    end
  end

endmodule

### verif/mutex_lock_manager_fifo_core_tb.sv
// Self-checking testbench for the mutex lock manager with per-mutex FIFO wait queues.
`timescale 1ns / 1ps

module mutex_lock_manager_fifo_core_tb;
  import mlm_pkg::*;

  // One lock-manager response as seen on the result channel.
  typedef struct packed {
    logic [ST_W-1:0]  status;
    logic [PID_W-1:0] handoff_pid;
    logic             handoff_valid;
  } lock_response_t;

  // Shadow copy of the mutex bank. It predicts the response of every accepted
  // request and checks the responses that the block returns, in order.
  class mutex_bank_scoreboard;
    bit               locked   [MUTEX_COUNT];
    bit [PID_W-1:0]   owner    [MUTEX_COUNT];
    bit [PID_W-1:0]   waiters  [MUTEX_COUNT][QUEUE_DEPTH];
    int unsigned      head     [MUTEX_COUNT];
    int unsigned      n_waiting[MUTEX_COUNT];
    lock_response_t   pending_responses[$];
    int unsigned      mismatches;

    function new();
      for (int m = 0; m < MUTEX_COUNT; m++) begin
        locked[m]    = 1'b0;
        owner[m]     = '0;
        head[m]      = 0;
        n_waiting[m] = 0;
      end
      mismatches = 0;
    endfunction

    // Update the shadow bank for one accepted request and queue its response.
    function void apply_request(bit op, bit [ID_W-1:0] id, bit [PID_W-1:0] pid);
      lock_response_t rsp;
      int unsigned    tail;
      rsp = '{status: ST_UNKNOWN, handoff_pid: '0, handoff_valid: 1'b0};
      if (id >= MUTEX_COUNT) begin
        rsp.status = ST_UNKNOWN;
      end else if (op == OP_WAIT) begin
        if (!locked[id]) begin
          locked[id] = 1'b1;
          owner[id]  = pid;
          rsp.status = ST_ACQUIRED;
        end else if (n_waiting[id] >= QUEUE_DEPTH) begin
          rsp.status = ST_FULL;
        end else begin
          tail = (head[id] + n_waiting[id]) % QUEUE_DEPTH;
          waiters[id][tail] = pid;
          n_waiting[id]++;
          rsp.status = ST_BLOCKED;
        end
      end else begin
        if (!locked[id] || owner[id] != pid) begin
          rsp.status = ST_NOT_OWNER;
        end else if (n_waiting[id] > 0) begin
          owner[id] = waiters[id][head[id]];
          head[id]  = (head[id] + 1) % QUEUE_DEPTH;
          n_waiting[id]--;
          rsp.status        = ST_HANDOFF;
          rsp.handoff_pid   = owner[id];
          rsp.handoff_valid = 1'b1;
        end else begin
          locked[id] = 1'b0;
          owner[id]  = '0;
          rsp.status = ST_FREED;
        end
      end
      pending_responses.push_back(rsp);
    endfunction

    // Compare one returned response with the oldest prediction.
    function void check_response(lock_response_t got);
      lock_response_t want;
      if (pending_responses.size() == 0) begin
        if (mismatches < 10)
          $display("ERROR: unexpected response status=%0d pid=%0d hv=%0b",
                   got.status, got.handoff_pid, got.handoff_valid);
        mismatches++;
        return;
      end
      want = pending_responses.pop_front();
      if (got.status !== want.status || got.handoff_pid !== want.handoff_pid ||
          got.handoff_valid !== want.handoff_valid) begin
        if (mismatches < 10)
          $display({"ERROR: response mismatch: expected status=%0d pid=%0d hv=%0b, ",
                    "got status=%0d pid=%0d hv=%0b"},
                   want.status, want.handoff_pid, want.handoff_valid,
                   got.status, got.handoff_pid, got.handoff_valid);
        mismatches++;
      end
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic             in_op = OP_WAIT;
  logic [ID_W-1:0]  in_mutex_id = '0;
  logic [PID_W-1:0] in_process_id = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [ST_W-1:0]  out_status;
  logic [PID_W-1:0] out_handoff_pid;
  logic             out_handoff_valid;

  mutex_bank_scoreboard lock_sb = new();

  mutex_lock_manager_fifo_core dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_op             (in_op),
    .in_mutex_id       (in_mutex_id),
    .in_process_id     (in_process_id),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_handoff_pid   (out_handoff_pid),
    .out_handoff_valid (out_handoff_valid)
  );

  // 2 ns clock.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Receiver backpressure: the stall pattern is redrawn at random among four modes.
  int unsigned stall_mode = 0;
  int unsigned stall_cycle = 0;
  always @(posedge clk) begin
    stall_cycle <= stall_cycle + 1;
    if (stall_cycle % 64 == 0)
      stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 1) == 1);
      2: out_ready <= (stall_cycle % 8 == 0);
      default: out_ready <= ($urandom_range(0, 3) != 0);
    endcase
  end

  // Check every response transaction against the prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      lock_sb.check_response('{status: out_status, handoff_pid: out_handoff_pid,
                               handoff_valid: out_handoff_valid});
  end

  // Present one request and hold it until it is accepted.
  task automatic send_request(bit op, bit [ID_W-1:0] id, bit [PID_W-1:0] pid);
    in_valid      <= 1'b1;
    in_op         <= op;
    in_mutex_id   <= id;
    in_process_id <= pid;
    do @(posedge clk); while (!in_ready);
    lock_sb.apply_request(op, id, pid);
  endtask

  // Random traffic in phases: each phase has its own wait/signal mix and may
  // focus on one mutex so that its queue fills up.
  task automatic run_random_traffic(int unsigned n_items);
    int unsigned      wait_pct;
    int               focus;
    int unsigned      burst_left;
    int unsigned      gap;
    bit               op;
    bit [ID_W-1:0]    id;
    bit [PID_W-1:0]   pid;
    wait_pct   = 50;
    focus      = -1;
    burst_left = 0;
    for (int unsigned i = 0; i < n_items; i++) begin
      if (i % 40 == 0) begin
        wait_pct = $urandom_range(15, 92);
        focus    = ($urandom_range(0, 1) == 1) ? int'($urandom_range(0, MUTEX_COUNT - 1)) : -1;
      end
      pid = PID_W'($urandom_range(0, 255));
      if ($urandom_range(0, 99) < 6) begin
        // Noise: unknown mutex ids.
        op = 1'($urandom_range(0, 1));
        id = ID_W'($urandom_range(MUTEX_COUNT, 7));
      end else begin
        if (focus >= 0 && $urandom_range(0, 3) != 0)
          id = ID_W'(focus);
        else
          id = ID_W'($urandom_range(0, MUTEX_COUNT - 1));
        if ($urandom_range(0, 99) < wait_pct) begin
          op = OP_WAIT;
          // Occasionally the owner asks again and queues behind itself.
          if (lock_sb.locked[id] && $urandom_range(0, 9) == 0)
            pid = lock_sb.owner[id];
        end else begin
          op = OP_SIGNAL;
          if (lock_sb.locked[id] && $urandom_range(0, 99) < 85)
            pid = lock_sb.owner[id];
        end
      end
      send_request(op, id, pid);

      // Sender bursts with random gaps in between.
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 12);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end else begin
        burst_left--;
      end
    end
    in_valid <= 1'b0;
  endtask

  // Main sequence: reset, directed cases, random traffic, drain.
  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Unknown mutex ids for both operations.
    send_request(OP_WAIT,   3'd7, 8'd255);
    send_request(OP_SIGNAL, 3'd4, 8'd0);
    // Signal on a free mutex is refused.
    send_request(OP_SIGNAL, 3'd0, 8'd0);
    // Acquire, owner waits behind itself, another waiter, then a non-owner signal.
    send_request(OP_WAIT,   3'd0, 8'd0);
    send_request(OP_WAIT,   3'd0, 8'd0);
    send_request(OP_WAIT,   3'd0, 8'd255);
    send_request(OP_SIGNAL, 3'd0, 8'd255);
    // Two handoffs in queue order, then the mutex is freed.
    send_request(OP_SIGNAL, 3'd0, 8'd0);
    send_request(OP_SIGNAL, 3'd0, 8'd0);
    send_request(OP_SIGNAL, 3'd0, 8'd255);
    // Last mutex, alternating bit patterns: acquire, one waiter, handoff, free, two unknown ids.
    send_request(OP_WAIT,   3'd3, 8'd170);
    send_request(OP_WAIT,   3'd3, 8'd85);
    send_request(OP_SIGNAL, 3'd3, 8'd170);
    send_request(OP_SIGNAL, 3'd3, 8'd85);
    send_request(OP_SIGNAL, 3'd5, 8'd170);
    send_request(OP_WAIT,   3'd6, 8'd85);

    run_random_traffic(950);

    // Drain outstanding responses, then wait on for stray responses.
    while (lock_sb.pending_responses.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (lock_sb.mismatches == 0)
      $display("mutex_lock_manager_fifo_core_tb passed");
    else
      $display("mutex_lock_manager_fifo_core_tb failed");
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #400000;
    $display("mutex_lock_manager_fifo_core_tb failed");
    $finish;
  end

endmodule
